/* rtl/msfd_pkg.sv */
// Package for the sync/type/length frame deframer.
// Holds register codes, reset values and the structs passed between modules.
// No dependencies.
package msfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned HCNT_W    = 3;

  localparam int unsigned MAX_LEN_LIMIT_DEF = 4096;

  localparam logic [BYTE_W-1:0]  SYNC_RST     = 8'hAA;
  localparam logic [BYTE_W-1:0]  TYPE_ONE_RST = 8'h41;
  localparam logic [BYTE_W-1:0]  TYPE_TWO_RST = 8'h43;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 13'd4096;

  // header bytes: type byte then four length bytes
  localparam logic [HCNT_W-1:0] HDR_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_VALUE    = 2'd0,
    REG_TYPE_CODE_ONE = 2'd1,
    REG_TYPE_CODE_TWO = 2'd2,
    REG_LENGTH_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  sync_value;
    logic [BYTE_W-1:0]  type_code_one;
    logic [BYTE_W-1:0]  type_code_two;
    logic [LIMIT_W-1:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_first;
    logic              is_last;
    logic              is_empty;
  } result_t;

endpackage

/* rtl/msfd_cfg_regs.sv */
// Configuration register file of the frame deframer.
// Plain write port, no read-back. Depends on msfd_pkg.
module msfd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msfd_pkg::CFG_W-1:0]       cfg_wdata,
  output msfd_pkg::cfg_t                   cfg
);

  msfd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (msfd_pkg::reg_idx_t'(cfg_index))
        msfd_pkg::REG_SYNC_VALUE:    cfg_nxt.sync_value    = cfg_wdata[msfd_pkg::BYTE_W-1:0];
        msfd_pkg::REG_TYPE_CODE_ONE: cfg_nxt.type_code_one = cfg_wdata[msfd_pkg::BYTE_W-1:0];
        msfd_pkg::REG_TYPE_CODE_TWO: cfg_nxt.type_code_two = cfg_wdata[msfd_pkg::BYTE_W-1:0];
        msfd_pkg::REG_LENGTH_LIMIT:  cfg_nxt.length_limit  = cfg_wdata[msfd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value    <= msfd_pkg::SYNC_RST;
      cfg_r.type_code_one <= msfd_pkg::TYPE_ONE_RST;
      cfg_r.type_code_two <= msfd_pkg::TYPE_TWO_RST;
      cfg_r.length_limit  <= msfd_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/msfd_parser.sv */
// Frame parser: hunt / header / payload state machine, one byte per step.
// Produces at most one result per byte. Depends on msfd_pkg.
module msfd_parser #(
  parameter int unsigned MAX_LEN_LIMIT = msfd_pkg::MAX_LEN_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msfd_pkg::cfg_t               cfg,
  input  logic                         step,
  input  logic [msfd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         res_valid,
  output msfd_pkg::result_t            res
);

  localparam int unsigned BL_W = $clog2(MAX_LEN_LIMIT + 1);
  localparam logic [msfd_pkg::LEN_W-1:0] MAX_LIM = msfd_pkg::LEN_W'(MAX_LEN_LIMIT);

  msfd_pkg::phase_t                  phase_r, phase_nxt;
  logic [msfd_pkg::HCNT_W-1:0]       hcnt_r, hcnt_nxt;
  logic [msfd_pkg::BYTE_W-1:0]       kind_r, kind_nxt;
  logic [msfd_pkg::LEN_W-1:0]        accum_r, accum_nxt;
  logic [BL_W-1:0]                   left_r, left_nxt;
  logic                              first_r, first_nxt;

  logic [msfd_pkg::LEN_W-1:0]        accum_sh;
  logic [msfd_pkg::LEN_W-1:0]        lim_eff;
  logic                              kind_ok;
  logic                              last;

  assign accum_sh = {accum_r[msfd_pkg::LEN_W-msfd_pkg::BYTE_W-1:0], rx_byte};
  assign lim_eff  = (msfd_pkg::LEN_W'(cfg.length_limit) < MAX_LIM)
                    ? msfd_pkg::LEN_W'(cfg.length_limit) : MAX_LIM;
  assign kind_ok  = (kind_r == cfg.type_code_one) || (kind_r == cfg.type_code_two);
  assign last     = (left_r <= BL_W'(1));

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    kind_nxt  = kind_r;
    accum_nxt = accum_r;
    left_nxt  = left_r;
    first_nxt = first_r;
    res_valid = 1'b0;
    res       = '0;
    res.frame_kind = kind_r;
    if (step) begin
      unique case (phase_r)
        msfd_pkg::PH_HEADER: begin
          if (hcnt_r == '0) begin
            kind_nxt = rx_byte;
            hcnt_nxt = msfd_pkg::HCNT_W'(1);
          end else begin
            accum_nxt = accum_sh;
            hcnt_nxt  = hcnt_r + msfd_pkg::HCNT_W'(1);
            if (hcnt_r == msfd_pkg::HDR_LAST) begin
              hcnt_nxt = '0;
              if (!kind_ok || (accum_sh > lim_eff)) begin
                phase_nxt = msfd_pkg::PH_HUNT;
              end else if (accum_sh == '0) begin
                // zero-length frame: single empty-marked result
                phase_nxt    = msfd_pkg::PH_HUNT;
                res_valid    = 1'b1;
                res.is_first = 1'b1;
                res.is_last  = 1'b1;
                res.is_empty = 1'b1;
              end else begin
                left_nxt  = accum_sh[BL_W-1:0];
                first_nxt = 1'b1;
                phase_nxt = msfd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        msfd_pkg::PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = rx_byte;
          res.is_first     = first_r;
          res.is_last      = last;
          first_nxt        = 1'b0;
          if (last) begin
            left_nxt  = '0;
            phase_nxt = msfd_pkg::PH_HUNT;
          end else begin
            left_nxt = left_r - BL_W'(1);
          end
        end
        default: begin
          phase_nxt = msfd_pkg::PH_HUNT;
          if (rx_byte == cfg.sync_value) begin
            phase_nxt = msfd_pkg::PH_HEADER;
            hcnt_nxt  = '0;
            accum_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= msfd_pkg::PH_HUNT;
      hcnt_r  <= '0;
      kind_r  <= '0;
      accum_r <= '0;
      left_r  <= '0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      kind_r  <= kind_nxt;
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

/* rtl/msfd_out_reg.sv */
// Result register of the frame deframer: holds one beat until the receiver takes it.
// Depends on msfd_pkg.
module msfd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msfd_pkg::result_t  push_res,
  output logic               can_take,
  input  logic               out_stall,
  output logic               out_valid,
  output msfd_pkg::result_t  out_res
);

  logic              valid_r;
  msfd_pkg::result_t res_r;

  // free when empty or when the held beat leaves this cycle
  assign can_take = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && push) begin
      res_r <= push_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/magic_sync_frame_deframer_unit.sv */
// Usage
// Sync-byte / type / length frame deframer, top level.
// Input channel: in_valid, in_stall, in_rx_byte; one received byte per beat.
// Result channel: out_valid, out_stall and the result fields; one beat per
// payload byte of an accepted frame, one empty-marked beat for a
// zero-length frame, nothing for hunt and header bytes.
// Configuration: cfg_we, cfg_index, cfg_wdata, written while idle.
// A byte is accepted into an input register, then parsed, and its result (if
// any) is loaded into the output register; a stall can hold the byte in the
// input register in between. One byte is taken per cycle while the receiver
// does not stall, the rate being set by the single parse step between the two registers.
// When the receiver stalls with a result held, the input register holds its
// byte and in_stall rises; nothing is dropped.
// Reset (rst_n low, synchronous) clears both registers' valid flags, puts
// the parser back to hunting and loads the register reset values.
// Depends on msfd_pkg, msfd_cfg_regs, msfd_parser, msfd_out_reg.
module magic_sync_frame_deframer_unit #(
  parameter int unsigned MAX_LEN_LIMIT = msfd_pkg::MAX_LEN_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [msfd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [msfd_pkg::BYTE_W-1:0]     out_frame_kind,
  output logic [msfd_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic                            out_is_first,
  output logic                            out_is_last,
  output logic                            out_is_empty,
  input  logic                            cfg_we,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msfd_pkg::CFG_W-1:0]      cfg_wdata
);

  msfd_pkg::cfg_t              cfg;
  msfd_pkg::result_t           p_res;
  msfd_pkg::result_t           o_res;
  logic                        p_valid;
  logic                        can_take;
  logic                        step;
  logic                        in_v_r;
  logic [msfd_pkg::BYTE_W-1:0] in_byte_r;

  assign step     = in_v_r && can_take;
  assign in_stall = in_v_r && !can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  msfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  msfd_parser #(
    .MAX_LEN_LIMIT (MAX_LEN_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .rx_byte   (in_byte_r),
    .res_valid (p_valid),
    .res       (p_res)
  );

  msfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p_valid),
    .push_res  (p_res),
    .can_take  (can_take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (o_res)
  );

  assign out_frame_kind   = o_res.frame_kind;
  assign out_payload_byte = o_res.payload_byte;
  assign out_is_first     = o_res.is_first;
  assign out_is_last      = o_res.is_last;
  assign out_is_empty     = o_res.is_empty;

endmodule
